// ===== hdl/speech_endpoint_detector_defines.svh =====
// assertion macros for the speech endpoint detector checker
`ifndef SPEECH_ENDPOINT_DETECTOR_DEFINES_SVH
`define SPEECH_ENDPOINT_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sed_pkg.sv =====
`timescale 1ns / 1ps

package sed_pkg;

	// register indexes
	localparam logic [2:0] REG_FRAME_SAMPLES        = 3'd0;
	localparam logic [2:0] REG_START_FRAMES         = 3'd1;
	localparam logic [2:0] REG_END_SILENCE_FRAMES   = 3'd2;
	localparam logic [2:0] REG_MAX_UTTERANCE_FRAMES = 3'd3;
	localparam logic [2:0] REG_MIN_SPEECH_FRAMES    = 3'd4;
	localparam logic [2:0] REG_ABSOLUTE_FLOOR_RMS   = 3'd5;
	localparam logic [2:0] REG_SPEECH_FLOOR_RATIO   = 3'd6;
	localparam logic [2:0] REG_SILENCE_FLOOR_RATIO  = 3'd7;

	// reset values
	localparam logic [12:0] RST_FRAME_SAMPLES        = 13'd480;
	localparam logic [7:0]  RST_START_FRAMES         = 8'd3;
	localparam logic [15:0] RST_END_SILENCE_FRAMES   = 16'd24;
	localparam logic [15:0] RST_MAX_UTTERANCE_FRAMES = 16'd334;
	localparam logic [15:0] RST_MIN_SPEECH_FRAMES    = 16'd10;
	localparam logic [14:0] RST_ABSOLUTE_FLOOR_RMS   = 15'd0;
	localparam logic [11:0] RST_SPEECH_FLOOR_RATIO   = 12'd768;
	localparam logic [11:0] RST_SILENCE_FLOOR_RATIO  = 12'd384;

	// noise floor smoothing weights, 0.95 and 0.05 in Q0.16
	localparam logic [15:0] NF_KEEP_Q16 = 16'd62259;
	localparam logic [11:0] NF_NEW_Q16  = 12'd3277;

	typedef struct packed {
		logic [12:0] frame_samples;
		logic [7:0]  start_frames;
		logic [15:0] end_silence_frames;
		logic [15:0] max_utterance_frames;
		logic [15:0] min_speech_frames;
		logic [14:0] absolute_floor_rms;
		logic [11:0] speech_floor_ratio;
		logic [11:0] silence_floor_ratio;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic samp;
		logic div_step;
		logic sqrt_load;
		logic sqrt_step;
		logic ev1;
		logic ev2;
		logic ev3;
		logic ev4;
		logic bend;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_end;
		logic blk;
		logic out_free;
	} sts_t;

	function automatic logic [15:0] sat16(input logic [15:0] x);
		return (x == 16'hFFFF) ? x : x + 16'd1;
	endfunction

	function automatic logic [39:0] max3(input logic [39:0] a, input logic [39:0] b,
		input logic [39:0] c);
		logic [39:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

// ===== hdl/sed_cfg.sv =====
`timescale 1ns / 1ps

module sed_cfg import sed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_samples        <= RST_FRAME_SAMPLES;
			cfg_q.start_frames         <= RST_START_FRAMES;
			cfg_q.end_silence_frames   <= RST_END_SILENCE_FRAMES;
			cfg_q.max_utterance_frames <= RST_MAX_UTTERANCE_FRAMES;
			cfg_q.min_speech_frames    <= RST_MIN_SPEECH_FRAMES;
			cfg_q.absolute_floor_rms   <= RST_ABSOLUTE_FLOOR_RMS;
			cfg_q.speech_floor_ratio   <= RST_SPEECH_FLOOR_RATIO;
			cfg_q.silence_floor_ratio  <= RST_SILENCE_FLOOR_RATIO;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_FRAME_SAMPLES:        cfg_q.frame_samples        <= pwdata[12:0];
				REG_START_FRAMES:         cfg_q.start_frames         <= pwdata[7:0];
				REG_END_SILENCE_FRAMES:   cfg_q.end_silence_frames   <= pwdata[15:0];
				REG_MAX_UTTERANCE_FRAMES: cfg_q.max_utterance_frames <= pwdata[15:0];
				REG_MIN_SPEECH_FRAMES:    cfg_q.min_speech_frames    <= pwdata[15:0];
				REG_ABSOLUTE_FLOOR_RMS:   cfg_q.absolute_floor_rms   <= pwdata[14:0];
				REG_SPEECH_FLOOR_RATIO:   cfg_q.speech_floor_ratio   <= pwdata[11:0];
				REG_SILENCE_FLOOR_RATIO:  cfg_q.silence_floor_ratio  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_FRAME_SAMPLES:        prdata = {19'd0, cfg_q.frame_samples};
			REG_START_FRAMES:         prdata = {24'd0, cfg_q.start_frames};
			REG_END_SILENCE_FRAMES:   prdata = {16'd0, cfg_q.end_silence_frames};
			REG_MAX_UTTERANCE_FRAMES: prdata = {16'd0, cfg_q.max_utterance_frames};
			REG_MIN_SPEECH_FRAMES:    prdata = {16'd0, cfg_q.min_speech_frames};
			REG_ABSOLUTE_FLOOR_RMS:   prdata = {17'd0, cfg_q.absolute_floor_rms};
			REG_SPEECH_FLOOR_RATIO:   prdata = {20'd0, cfg_q.speech_floor_ratio};
			REG_SILENCE_FLOOR_RATIO:  prdata = {20'd0, cfg_q.silence_floor_ratio};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/sed_ctrl.sv =====
`timescale 1ns / 1ps

module sed_ctrl import sed_pkg::*; #(
	parameter int DIV_STEPS  = 59,
	parameter int SQRT_STEPS = 30
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int CNTW = $clog2(DIV_STEPS + SQRT_STEPS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SAMP = 4'd1;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_SQI  = 4'd3;
	localparam logic [3:0] ST_SQRT = 4'd4;
	localparam logic [3:0] ST_EV1  = 4'd5;
	localparam logic [3:0] ST_EV2  = 4'd6;
	localparam logic [3:0] ST_EV3  = 4'd7;
	localparam logic [3:0] ST_EV4  = 4'd8;
	localparam logic [3:0] ST_CHK  = 4'd9;

	logic [3:0]      state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) state_d = ST_SAMP;
			end
			ST_SAMP: begin
				cmd.samp = 1'b1;
				if (sts.frame_end) begin
					state_d = ST_DIV;
					cnt_d = CNTW'(DIV_STEPS - 1);
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) state_d = ST_SQI;
			end
			ST_SQI: begin
				cmd.sqrt_load = 1'b1;
				cnt_d = CNTW'(SQRT_STEPS - 1);
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) state_d = ST_EV1;
			end
			ST_EV1: begin
				cmd.ev1 = 1'b1;
				state_d = ST_EV2;
			end
			ST_EV2: begin
				cmd.ev2 = 1'b1;
				state_d = ST_EV3;
			end
			ST_EV3: begin
				cmd.ev3 = 1'b1;
				state_d = ST_EV4;
			end
			ST_EV4: begin
				cmd.ev4 = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (!sts.blk) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.bend = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== hdl/sed_dp.sv =====
`timescale 1ns / 1ps

module sed_dp import sed_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = 4096,
	parameter int ZCR_MIN_Q16 = 0,
	parameter int ZCR_MAX_Q16 = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [15:0] in_sample,
	input  logic        in_sample_valid,
	input  logic        in_block_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_data
);

	localparam int NW = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int EW = 31 + $clog2(MAX_FRAME_SAMPLES);
	localparam int DW = EW + 16;
	localparam int SW = DW + (DW % 2);
	localparam int RW = SW / 2;
	localparam int ZW = NW + 16;

	// latched input item
	logic signed [15:0] smp_q;
	logic vld_q, blk_q;

	// frame accumulators
	logic [NW-1:0] fill_q, cross_q;
	logic [EW-1:0] energy_q;
	logic [15:0]   last_q;
	logic          have_q;

	// frame-end working registers
	logic [NW-1:0] n_q, zc_q, rem_q;
	logic [DW-1:0] dq_q;
	logic [SW-1:0] rad_q;
	logic [RW-1:0] root_q;
	logic [RW+1:0] srem_q;
	logic [39:0]   prod_q;
	logic          like_q, loud_q;

	// detector state
	logic [23:0] nf_q;
	logic        insp_q, started_q;
	logic [15:0] run_q, quiet_q, len_q, total_q;

	logic        ov_q;
	logic [2:0]  od_q;

	logic [NW-1:0] n_w, cross_w;
	logic [NW:0]   fill_w;
	logic signed [31:0] sq_w;
	logic [EW-1:0] energy_w;
	logic          fend;
	logic [NW:0]   dt, dsub;
	logic          dge;
	logic [RW+3:0] r2, trial, r2sub;
	logic          sge;
	logic [23:0]   rms_w, nf_eff;
	logic [39:0]   rms16, start_lvl, stop_lvl;
	logic [ZW-1:0] zc_full, zlo, zhi;
	logic          zok;
	logic [40:0]   nf_sum;
	logic [15:0]   run_new;
	logic          hit, endp, clr;

	// frame length clamped to 1..MAX_FRAME_SAMPLES
	assign n_w = (cfg.frame_samples == '0) ? NW'(1) :
		((32'(cfg.frame_samples) > 32'(MAX_FRAME_SAMPLES)) ? NW'(MAX_FRAME_SAMPLES) :
		NW'(cfg.frame_samples));

	assign sq_w = smp_q * smp_q;
	assign energy_w = energy_q + EW'(unsigned'(sq_w));
	assign cross_w = cross_q + NW'(have_q && (smp_q[15] != last_q[15]));
	assign fill_w = {1'b0, fill_q} + 1'b1;
	assign fend = vld_q && (fill_w >= {1'b0, n_w});

	// restoring divide, one quotient bit per step
	assign dt = {rem_q, dq_q[DW-1]};
	assign dsub = dt - {1'b0, n_q};
	assign dge = dt >= {1'b0, n_q};

	// digit-by-digit square root, two radicand bits per step
	assign r2 = {srem_q, rad_q[SW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign r2sub = r2 - trial;
	assign sge = r2 >= trial;

	assign rms_w = root_q[23:0];
	assign rms16 = {8'd0, rms_w, 8'd0};
	assign nf_eff = (nf_q == '0) ? {1'b0, cfg.absolute_floor_rms, 8'd0} : nf_q;
	assign start_lvl = max3(prod_q, {9'd0, cfg.absolute_floor_rms, 16'd0}, 40'h1_0000);
	assign stop_lvl = max3(prod_q, {10'd0, cfg.absolute_floor_rms, 15'd0}, 40'h1_0000);

	assign zc_full = {zc_q, 16'd0};
	assign zlo = ZW'(ZCR_MIN_Q16) * ZW'(n_q);
	assign zhi = ZW'(ZCR_MAX_Q16) * ZW'(n_q);
	assign zok = (zc_full >= zlo) && (zc_full <= zhi);

	// noise floor smoothing with round to nearest
	assign nf_sum = {1'b0, prod_q} + 41'({17'd0, rms_w}) * 41'(NF_NEW_Q16) + 41'd32768;
	assign run_new = like_q ? sat16(run_q) : 16'd0;

	assign hit = insp_q && ((quiet_q >= cfg.end_silence_frames) ||
		(total_q >= cfg.max_utterance_frames));
	assign endp = hit && (len_q >= cfg.min_speech_frames);
	assign clr = hit && !endp;

	assign sts.frame_end = fend;
	assign sts.blk = blk_q;
	assign sts.out_free = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_data = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			energy_q <= '0;
			cross_q <= '0;
			last_q <= '0;
			have_q <= 1'b0;
			nf_q <= '0;
			insp_q <= 1'b0;
			run_q <= '0;
			quiet_q <= '0;
			len_q <= '0;
			total_q <= '0;
			started_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (cmd.samp && vld_q) begin
				last_q <= smp_q;
				have_q <= 1'b1;
				if (fend) begin
					fill_q <= '0;
					energy_q <= '0;
					cross_q <= '0;
				end else begin
					fill_q <= fill_w[NW-1:0];
					energy_q <= energy_w;
					cross_q <= cross_w;
				end
			end
			if (cmd.ev1) nf_q <= nf_eff;
			if (cmd.ev4) begin
				total_q <= sat16(total_q);
				if (!insp_q) begin
					if (!like_q) nf_q <= nf_sum[39:16];
					run_q <= run_new;
					if (run_new >= {8'd0, cfg.start_frames}) begin
						insp_q <= 1'b1;
						started_q <= 1'b1;
						len_q <= {8'd0, cfg.start_frames};
						quiet_q <= '0;
					end
				end else if (loud_q) begin
					len_q <= sat16(len_q);
					quiet_q <= '0;
				end else begin
					quiet_q <= sat16(quiet_q);
				end
			end
			if (cmd.bend) begin
				ov_q <= 1'b1;
				started_q <= 1'b0;
				if (clr) begin
					// utterance too short: back to the reset picture
					fill_q <= '0;
					energy_q <= '0;
					cross_q <= '0;
					last_q <= '0;
					have_q <= 1'b0;
					nf_q <= '0;
					insp_q <= 1'b0;
					run_q <= '0;
					quiet_q <= '0;
					len_q <= '0;
					total_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			smp_q <= in_sample;
			vld_q <= in_sample_valid;
			blk_q <= in_block_end;
		end
		if (cmd.samp && fend) begin
			n_q <= n_w;
			zc_q <= cross_w;
			dq_q <= {energy_w, 16'd0};
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= dge ? dsub[NW-1:0] : dt[NW-1:0];
			dq_q <= {dq_q[DW-2:0], dge};
		end
		if (cmd.sqrt_load) begin
			rad_q <= SW'(dq_q);
			root_q <= '0;
			srem_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[SW-3:0], 2'b00};
			srem_q <= sge ? r2sub[RW+1:0] : r2[RW+1:0];
			root_q <= {root_q[RW-2:0], sge};
		end
		if (cmd.ev1) prod_q <= 40'(nf_eff) * 40'(cfg.speech_floor_ratio);
		if (cmd.ev2) begin
			like_q <= (rms16 >= start_lvl) && zok;
			prod_q <= 40'(nf_q) * 40'(cfg.silence_floor_ratio);
		end
		if (cmd.ev3) begin
			loud_q <= rms16 >= stop_lvl;
			prod_q <= 40'(nf_q) * 40'(NF_KEEP_Q16);
		end
		if (cmd.bend) od_q <= {insp_q && !clr, endp, started_q};
	end

endmodule

// ===== hdl/speech_endpoint_detector.sv =====
`timescale 1ns / 1ps

// Energy and zero-crossing speech endpoint detector. Each sample transaction on the s_ side
// with s_tuser high updates the frame sums; when a frame fills, the frame's RMS is formed by a
// one-bit-per-cycle restoring divider followed by a two-bits-per-cycle square root unit, then
// compared against start and stop levels derived from an adaptive noise floor, and the
// idle/speaking tracker advances. A transaction with s_tlast high produces exactly one result
// on the m_ side; all others produce none. One item is handled at a time: the next item is
// accepted only once the current one is through. The divider forms
// DW = 47 + clog2(MAX_FRAME_SAMPLES) quotient bits and the square root RW = ceil(DW/2) root
// bits. The result sits in an output register, so a stalled m_ side only holds the block on
// its next block end. The user must write the registers through the APB port only while no
// item is in flight; the block itself does not enforce this.
module speech_endpoint_detector import sed_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = 4096,
	parameter int ZCR_MIN_Q16 = 0,
	parameter int ZCR_MAX_Q16 = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        s_tuser,   // [0] sample_valid
	input  logic        s_tlast,   // block_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] speech_started, [1] endpointed, [2] speaking
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// divider and square root lengths for the sequencer; the datapath derives its own from MAX_FRAME_SAMPLES
	localparam int DW = 47 + $clog2(MAX_FRAME_SAMPLES);
	localparam int RW = (DW + (DW % 2)) / 2;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic [2:0] res;

	assign m_tdata = {5'd0, res};

	sed_cfg u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// sequencer: sample update, divide, square root, level compare, block-end check
	sed_ctrl #(.DIV_STEPS(DW), .SQRT_STEPS(RW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	sed_dp #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
		.ZCR_MIN_Q16(ZCR_MIN_Q16),
		.ZCR_MAX_Q16(ZCR_MAX_Q16)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .sts(sts),
		.in_sample(s_tdata), .in_sample_valid(s_tuser), .in_block_end(s_tlast),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
	);

endmodule

// ===== hdl/sed_chk.sv =====
`timescale 1ns / 1ps
`include "speech_endpoint_detector_defines.svh"

module sed_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	`SED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`SED_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second item taken while one is in work")
	`SED_ASSERT_NOW(a_endp_speaking, m_tvalid && m_tdata[1], m_tdata[2], "endpoint reported outside speech")
	`SED_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:3] == 5'd0, "result padding not zero")

endmodule

bind speech_endpoint_detector sed_chk u_sed_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import sed_pkg::*;

	localparam int MAX_N = 4096;
	localparam longint unsigned ZC_LO = 0;
	localparam longint unsigned ZC_HI = 65535;
	localparam int DRAIN_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	speech_endpoint_detector dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic started;
		logic endp;
		logic talking;
	} verdict_t;

	// expected block verdicts, oldest first
	verdict_t verdict_q[$];
	int errors = 0;
	int items_sent = 0;
	int verdicts_seen = 0;
	int frames_closed = 0;
	bit idle_on = 1'b1;
	int hold_cycles = 0;

	// detector mirror
	cfg_t cfg;
	int unsigned fill_n, zc_cnt, run_sp, run_q, utt_len, frames_seen;
	longint unsigned nrg, floor_q8;
	int prev_s;
	bit prev_ok, talking, began;

	function automatic longint unsigned sqrt64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic int unsigned inc_sat(int unsigned x);
		return (x < 65535) ? x + 1 : 65535;
	endfunction

	function automatic longint unsigned max_of3(longint unsigned a, longint unsigned b,
		longint unsigned c);
		longint unsigned m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	task automatic clear_mirror();
		fill_n = 0; nrg = 0; zc_cnt = 0; prev_s = 0; prev_ok = 0;
		floor_q8 = 0; talking = 0; run_sp = 0; run_q = 0; utt_len = 0;
		frames_seen = 0; began = 0;
	endtask

	task automatic close_frame(int unsigned n);
		longint unsigned rms, rms16, zc, lvl_start, lvl_stop;
		bit loud;
		rms = sqrt64((nrg << 16) / n);
		rms16 = rms << 8;
		zc = longint'(zc_cnt) << 16;
		frames_closed++;
		if (floor_q8 == 0) floor_q8 = longint'(cfg.absolute_floor_rms) << 8;
		lvl_start = max_of3(floor_q8 * cfg.speech_floor_ratio,
			longint'(cfg.absolute_floor_rms) << 16, 64'd1 << 16);
		lvl_stop = max_of3(floor_q8 * cfg.silence_floor_ratio,
			longint'(cfg.absolute_floor_rms) << 15, 64'd1 << 16);
		loud = rms16 >= lvl_start && zc >= ZC_LO * n && zc <= ZC_HI * n;
		frames_seen = inc_sat(frames_seen);
		if (!talking) begin
			// floor only tracks frames that do not look like speech
			if (!loud) floor_q8 = (floor_q8 * 62259 + rms * 3277 + 32768) >> 16;
			run_sp = loud ? inc_sat(run_sp) : 0;
			if (run_sp >= cfg.start_frames) begin
				talking = 1;
				began = 1;
				utt_len = cfg.start_frames;
				run_q = 0;
			end
		end else if (rms16 >= lvl_stop) begin
			utt_len = inc_sat(utt_len);
			run_q = 0;
		end else begin
			run_q = inc_sat(run_q);
		end
	endtask

	// mirror of one accepted sample transaction
	task automatic predict_item(logic [15:0] smp, logic vld, logic last);
		int unsigned n;
		int s;
		verdict_t v;
		if (vld) begin
			n = (cfg.frame_samples == 0) ? 1 :
				(cfg.frame_samples > MAX_N) ? MAX_N : cfg.frame_samples;
			s = $signed(smp);
			if (prev_ok && ((s < 0) != (prev_s < 0))) zc_cnt++;
			prev_s = s;
			prev_ok = 1;
			nrg += longint'(s < 0 ? -s : s) * longint'(s < 0 ? -s : s);
			fill_n++;
			if (fill_n >= n) begin
				close_frame(n);
				fill_n = 0; nrg = 0; zc_cnt = 0;
			end
		end
		if (last) begin
			v.started = began;
			v.endp = 1'b0;
			if (talking && (run_q >= cfg.end_silence_frames ||
				frames_seen >= cfg.max_utterance_frames)) begin
				if (utt_len >= cfg.min_speech_frames) v.endp = 1'b1;
				else clear_mirror();
			end
			began = 0;
			v.talking = talking;
			verdict_q.push_back(v);
		end
	endtask

	// drive one sample transaction, with random idle cycles in front while idle_on is set
	task automatic send_item(logic [15:0] smp, logic vld, logic last);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 6) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = smp;
		s_tuser = vld;
		s_tlast = last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(smp, vld, last);
		items_sent++;
	endtask

	// wait until the block has nothing left in flight
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (verdict_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		// registers change only with nothing in flight
		drain();
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_FRAME_SAMPLES:        cfg.frame_samples = val[12:0];
			REG_START_FRAMES:         cfg.start_frames = val[7:0];
			REG_END_SILENCE_FRAMES:   cfg.end_silence_frames = val[15:0];
			REG_MAX_UTTERANCE_FRAMES: cfg.max_utterance_frames = val[15:0];
			REG_MIN_SPEECH_FRAMES:    cfg.min_speech_frames = val[15:0];
			REG_ABSOLUTE_FLOOR_RMS:   cfg.absolute_floor_rms = val[14:0];
			REG_SPEECH_FLOOR_RATIO:   cfg.speech_floor_ratio = val[11:0];
			default:                  cfg.silence_floor_ratio = val[11:0];
		endcase
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic set_all(int fs, int st, int es, int mu, int ms, int af, int sr, int qr);
		write_reg(REG_FRAME_SAMPLES, fs);
		write_reg(REG_START_FRAMES, st);
		write_reg(REG_END_SILENCE_FRAMES, es);
		write_reg(REG_MAX_UTTERANCE_FRAMES, mu);
		write_reg(REG_MIN_SPEECH_FRAMES, ms);
		write_reg(REG_ABSOLUTE_FLOOR_RMS, af);
		write_reg(REG_SPEECH_FLOOR_RATIO, sr);
		write_reg(REG_SILENCE_FLOOR_RATIO, qr);
	endtask

	// loud samples take a random sign, quiet ones stay near zero, noise is anything
	function automatic logic [15:0] make_sample(int kind);
		int a;
		case (kind)
			0: a = $urandom_range(40);
			1: a = $urandom_range(32767, 2000);
			default: return 16'($urandom);
		endcase
		return ($urandom_range(1) != 0) ? 16'(-a) : 16'(a);
	endfunction

	// a run of blocks shaped as quiet / talk / quiet, each block closing on tlast
	task automatic send_utterances(int nitems);
		int kind, left, blk;
		kind = 0;
		left = $urandom_range(30, 4);
		blk = $urandom_range(8, 1);
		repeat (nitems) begin
			if (left == 0) begin
				kind = (kind == 1) ? 0 : 1;
				if ($urandom_range(9) == 0) kind = 2;
				left = $urandom_range(40, 3);
			end
			left--;
			blk--;
			send_item(make_sample(kind), $urandom_range(19) != 0, blk == 0);
			if (blk == 0) blk = $urandom_range(10, 1);
		end
		send_item(make_sample(kind), 1'b1, 1'b1);
	endtask

	task automatic test_directed();
		set_all(2, 1, 2, 30, 2, 100, 768, 384);
		// field extremes and an idle item
		send_item(16'h8000, 1'b1, 1'b0);
		send_item(16'h7FFF, 1'b1, 1'b1);
		send_item(16'h0000, 1'b0, 1'b0);
		send_item(16'hFFFF, 1'b1, 1'b0);
		send_item(16'h0001, 1'b1, 1'b1);
		// empty block
		send_item(16'h1234, 1'b0, 1'b1);
		// short loud burst then silence: utterance too short
		write_reg(REG_MIN_SPEECH_FRAMES, 50);
		repeat (4) send_item(make_sample(1), 1'b1, 1'b0);
		repeat (10) send_item(make_sample(0), 1'b1, 1'b1);
		drain();
		// zero start frames, frame size 0 acts as 1
		set_all(0, 0, 0, 0, 0, 0, 0, 0);
		send_item(16'h0000, 1'b1, 1'b1);
		send_item(16'h4000, 1'b1, 1'b1);
		send_item(16'hC000, 1'b1, 1'b1);
		drain();
		// frame size above range, then shrunk mid-frame
		set_all(8191, 255, 65535, 65535, 65535, 32767, 4095, 4095);
		repeat (3) send_item(make_sample(1), 1'b1, 1'b0);
		send_item(16'h7FFF, 1'b1, 1'b1);
		drain();
		write_reg(REG_FRAME_SAMPLES, 3);
		send_item(16'h8001, 1'b1, 1'b1);
		drain();
	endtask

	// endpoint reached and then held on later block ends
	task automatic test_endpoint();
		set_all(2, 2, 3, 65535, 3, 50, 768, 384);
		repeat (20) send_item(make_sample(1), 1'b1, $urandom_range(3) == 0);
		repeat (16) send_item(make_sample(0), 1'b1, $urandom_range(2) == 0);
		send_item(make_sample(0), 1'b1, 1'b1);
		drain();
	endtask

	task automatic test_random_settings();
		idle_on = 1'b0;
		set_all(3, 2, 4, 60, 4, 80, 640, 320);
		send_utterances(300);
		drain();
		idle_on = 1'b1;
		repeat (5) begin
			set_all($urandom_range(6, 1), $urandom_range(4), $urandom_range(8),
				$urandom_range(120), $urandom_range(10), $urandom_range(300),
				$urandom_range(1200, 256), $urandom_range(700, 128));
			send_utterances(200);
			drain();
		end
	endtask

	// receiver stalls for a long time so the block backs up its input
	task automatic test_backpressure();
		set_all(1, 1, 2, 200, 1, 30, 768, 384);
		hold_cycles = 3000;
		send_utterances(280);
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < 6);
		end
	end

	// compare each result transaction with the oldest expected verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			verdicts_seen++;
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %b", $time, m_tdata[2:0]);
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[0] !== want.started) begin
					errors++;
					$display("%0t: speech_started expected %b got %b", $time,
						want.started, m_tdata[0]);
				end
				if (m_tdata[1] !== want.endp) begin
					errors++;
					$display("%0t: endpointed expected %b got %b", $time,
						want.endp, m_tdata[1]);
				end
				if (m_tdata[2] !== want.talking) begin
					errors++;
					$display("%0t: speaking expected %b got %b", $time,
						want.talking, m_tdata[2]);
				end
			end
		end
	end

	initial begin
		cfg = '{RST_FRAME_SAMPLES, RST_START_FRAMES, RST_END_SILENCE_FRAMES,
			RST_MAX_UTTERANCE_FRAMES, RST_MIN_SPEECH_FRAMES, RST_ABSOLUTE_FLOOR_RMS,
			RST_SPEECH_FLOOR_RATIO, RST_SILENCE_FLOOR_RATIO};
		clear_mirror();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_endpoint();
		test_random_settings();
		test_backpressure();
		$display("covered %0d sample transactions, %0d frames, %0d block results",
			items_sent, frames_closed, verdicts_seen);
		$display("settings swept from frame size 0 to 8191, ratios and floors at both ends");
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("timeout with %0d results outstanding", verdict_q.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
